/* design/set_assoc_tag_lru_engine_core_macros.svh */
// Assertion macros shared by the tag and replacement engine.
// No dependencies; included by the files that carry concurrent checks.
`ifndef SET_ASSOC_TAG_LRU_ENGINE_CORE_MACROS_SVH
`define SET_ASSOC_TAG_LRU_ENGINE_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define SALRU_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define SALRU_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* design/salru_pkg.sv */
// Package of the tag and replacement engine: geometry, set row type and
// address decode helpers. No dependencies.
package salru_pkg;

   // Cache geometry
   localparam int SET_COUNT  = 64;
   localparam int NUM_WAYS   = 4;
   localparam int LINE_BYTES = 64;
   localparam int ADDR_BITS  = 48;

   // Fixed field widths of the channels
   localparam int ADDR_W    = 48;
   localparam int OUT_WAY_W = 2;

   // Address split
   localparam int OFS       = $clog2(LINE_BYTES + 1) - 1;
   localparam int SETB      = $clog2(SET_COUNT);
   localparam int SET_W     = (SETB > 0) ? SETB : 1;
   localparam int EFF_ABITS = (ADDR_BITS > ADDR_W) ? ADDR_W : ADDR_BITS;
   localparam int LOW       = OFS + SETB;
   localparam bit HAS_TAG   = (EFF_ABITS > LOW);
   localparam int TAG_W     = HAS_TAG ? (EFF_ABITS - LOW) : 1;
   localparam logic [ADDR_W-1:0] ADDR_MASK = ADDR_W'((65'd1 << EFF_ABITS) - 65'd1);

   // Way index and age widths
   localparam int WAY_W = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
   localparam int AGE_W = WAY_W;
   localparam logic [AGE_W-1:0] AGE_MAX = AGE_W'(NUM_WAYS - 1);

   typedef enum logic {
      KIND_LOOKUP = 1'b0,
      KIND_FILL   = 1'b1
   } kind_type;

   // One set: all ways' tags, ages and valid bits in one memory row
   typedef struct packed {
      logic [NUM_WAYS-1:0]            valid;
      logic [NUM_WAYS-1:0][AGE_W-1:0] age;
      logic [NUM_WAYS-1:0][TAG_W-1:0] tag;
   } row_type;

   // Outcome of one transaction
   typedef struct packed {
      logic             hit;
      logic [WAY_W-1:0] way;
      logic             replaced;
   } result_type;

   // Set index; the field is folded into range when SET_COUNT is not a power of two
   function automatic logic [SET_W-1:0] set_of(input logic [ADDR_W-1:0] addr);
      logic [ADDR_W-1:0] am;
      logic [SET_W-1:0]  f;
      am = addr & ADDR_MASK;
      f  = (SETB == 0) ? '0 : SET_W'(am >> OFS);
      if ((SETB > 0) && ({1'b0, f} >= (SET_W + 1)'(SET_COUNT))) begin
         f = f - SET_W'(SET_COUNT);
      end
      return f;
   endfunction

   // Tag field; zero when offset and set take up every address bit
   function automatic logic [TAG_W-1:0] tag_of(input logic [ADDR_W-1:0] addr);
      logic [ADDR_W-1:0] am;
      am = addr & ADDR_MASK;
      return HAS_TAG ? TAG_W'(am >> LOW) : '0;
   endfunction

endpackage

/* design/salru_set_update.sv */
// Per-set lookup, victim selection and age update of the tag engine.
// Depends on salru_pkg.
module salru_set_update (
   input  salru_pkg::kind_type          kind,
   input  logic [salru_pkg::TAG_W-1:0]  tag,
   input  salru_pkg::row_type           row_cur,
   output salru_pkg::row_type           row_new,
   output salru_pkg::result_type        res
);

   logic                          hit;
   logic [salru_pkg::WAY_W-1:0]   hit_way;
   logic [salru_pkg::AGE_W-1:0]   hit_age;
   logic                          found_inv;
   logic [salru_pkg::WAY_W-1:0]   victim;
   logic [salru_pkg::AGE_W-1:0]   best;

   // Tag search: lowest valid matching way wins
   always_comb begin
      hit     = 1'b0;
      hit_way = '0;
      for (int w = 0; w < salru_pkg::NUM_WAYS; w++) begin
         if (!hit && row_cur.valid[w] && (row_cur.tag[w] == tag)) begin
            hit     = 1'b1;
            hit_way = salru_pkg::WAY_W'(w);
         end
      end
      hit_age = row_cur.age[hit_way];
   end

   // Victim: first invalid way, else the oldest with later ways winning ties
   always_comb begin
      found_inv = 1'b0;
      victim    = '0;
      best      = '0;
      for (int w = 0; w < salru_pkg::NUM_WAYS; w++) begin
         if (!found_inv) begin
            if (!row_cur.valid[w]) begin
               found_inv = 1'b1;
               victim    = salru_pkg::WAY_W'(w);
            end else if (row_cur.age[w] >= best) begin
               best   = row_cur.age[w];
               victim = salru_pkg::WAY_W'(w);
            end
         end
      end
   end

   // New row contents and result
   always_comb begin
      row_new = row_cur;
      res     = '0;
      if (kind == salru_pkg::KIND_LOOKUP) begin
         res.hit = hit;
         res.way = hit_way;
         if (hit) begin
            for (int w = 0; w < salru_pkg::NUM_WAYS; w++) begin
               if (row_cur.age[w] < hit_age) begin
                  row_new.age[w] = row_cur.age[w] + salru_pkg::AGE_W'(1);
               end
            end
            row_new.age[hit_way] = '0;
         end
      end else begin
         res.way      = victim;
         res.replaced = !found_inv;
         for (int w = 0; w < salru_pkg::NUM_WAYS; w++) begin
            if (row_cur.age[w] < salru_pkg::AGE_MAX) begin
               row_new.age[w] = row_cur.age[w] + salru_pkg::AGE_W'(1);
            end
         end
         row_new.age[victim]   = '0;
         row_new.valid[victim] = 1'b1;
         row_new.tag[victim]   = tag;
      end
   end

endmodule

/* design/set_assoc_tag_lru_engine_core.sv */
// Top level of the set-associative tag and replacement engine.
// Depends on salru_pkg, salru_set_update and the assertion macro header.
//
// Usage:
//   req channel: one transaction is a lookup (tuser = 0) or a fill (tuser = 1)
//   of the byte address in tdata. rsp channel: one transaction per request,
//   in order, carrying hit, way and replaced_valid.
//   The set row is read from memory into a register when the request is
//   taken, and the update lands in the output register when the update
//   stage completes, which waits while an earlier result is held on rsp.
//   Throughput: one request per cycle unless rsp stalls. The set row is read
//   at the accepting edge and written back when the stage completes; a request
//   taken as its set is written back takes the new row from a forward register.
//   Reset: clears the per-set init flags at once, so every set reads as all
//   ways invalid with age zero; no clearing sweep, req is ready right away.
//   Stall: while a result waits on rsp, one more request may be read; it then
//   holds in the update stage and req_tready drops until rsp is taken.
`include "set_assoc_tag_lru_engine_core_macros.svh"

module set_assoc_tag_lru_engine_core (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // [47:0] address
   input  logic        req_tuser,   // [0] kind (0 lookup, 1 fill)
   // response channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata    // [0] hit, [2:1] way, [3] replaced_valid, [7:4] zero
);

   // Update stage state
   logic                              busy_ff, busy_in;
   logic                              fwd_ff, fwd_in;
   logic                              init_rd_ff;
   salru_pkg::kind_type               kind_ff;
   logic [salru_pkg::TAG_W-1:0]       tag_ff;
   logic [salru_pkg::SET_W-1:0]       set_ff;
   salru_pkg::row_type                rd_row_ff;
   salru_pkg::row_type                fwd_row_ff;
   logic [salru_pkg::SET_COUNT-1:0]   row_init_ff, row_init_in;

   // Output register
   logic                              rsp_valid_ff, rsp_valid_in;
   logic [7:0]                        rsp_data_ff;

   // Set memory: one row per set
   salru_pkg::row_type                row_mem [salru_pkg::SET_COUNT];

   logic                              accept;
   logic                              complete;
   logic [salru_pkg::SET_W-1:0]       req_set;
   logic [salru_pkg::TAG_W-1:0]       req_tag;
   salru_pkg::row_type                row_cur;
   salru_pkg::row_type                row_new;
   salru_pkg::result_type             res;

   // Handshake
   assign complete   = busy_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !busy_ff || complete;
   assign accept     = req_tvalid && req_tready;
   assign req_set    = salru_pkg::set_of(req_tdata);
   assign req_tag    = salru_pkg::tag_of(req_tdata);

   // Row in work: forwarded write, memory data, or an untouched set
   always_comb begin
      if (fwd_ff) begin
         row_cur = fwd_row_ff;
      end else if (init_rd_ff) begin
         row_cur = rd_row_ff;
      end else begin
         row_cur = '0;
      end
   end

   salru_set_update u_update (
      .kind    (kind_ff),
      .tag     (tag_ff),
      .row_cur (row_cur),
      .row_new (row_new),
      .res     (res)
   );

   // Memory write port
   always_ff @(posedge clock) begin
      if (complete) begin
         row_mem[set_ff] <= row_new;
      end
   end

   // Memory read port, registered
   always_ff @(posedge clock) begin
      if (accept) begin
         rd_row_ff <= row_mem[req_set];
      end
   end

   // Next-state logic of control
   always_comb begin
      busy_in = busy_ff;
      if (accept) begin
         busy_in = 1'b1;
      end else if (complete) begin
         busy_in = 1'b0;
      end
      fwd_in = fwd_ff;
      if (accept) begin
         fwd_in = complete && (req_set == set_ff);
      end else if (complete) begin
         fwd_in = 1'b0;
      end
      row_init_in = row_init_ff;
      if (complete) begin
         row_init_in[set_ff] = 1'b1;
      end
      rsp_valid_in = rsp_valid_ff;
      if (complete) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         fwd_ff       <= 1'b0;
         row_init_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         fwd_ff       <= fwd_in;
         row_init_ff  <= row_init_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         kind_ff    <= salru_pkg::kind_type'(req_tuser);
         tag_ff     <= req_tag;
         set_ff     <= req_set;
         init_rd_ff <= row_init_ff[req_set];
         fwd_row_ff <= row_new;
      end
      if (complete) begin
         rsp_data_ff <= {4'b0000, res.replaced, salru_pkg::OUT_WAY_W'(res.way), res.hit};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // Checks
   `SALRU_ASSERT_NOW(a_fwd_busy, clock, reset, fwd_ff, busy_ff, "forward flag without work in stage")
   `SALRU_ASSERT_NEXT(a_done_shows, clock, reset, complete, rsp_tvalid, "finished transaction not presented")
   `SALRU_ASSERT_NOW(a_hit_no_repl, clock, reset, rsp_tvalid, !(rsp_tdata[0] && rsp_tdata[3]), "hit and replacement together")
   `SALRU_ASSERT_NEXT(a_init_set, clock, reset, complete, row_init_ff[$past(set_ff)], "written set not marked")
   `SALRU_ASSERT_NEXT(a_stall_hold, clock, reset, busy_ff && !complete, busy_ff && $stable(set_ff), "stalled stage lost its set")

endmodule

/* tb/set_assoc_tag_lru_engine_core_checker.sv */
`timescale 1ns / 100ps
// Scoreboard for the set-associative tag and replacement engine: watches both
// stream channels, predicts hit/way/eviction per request, and compares in order.
// Depends on salru_pkg for geometry, the kind enum and channel widths.
module set_assoc_tag_lru_engine_core_checker (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_tvalid,
   input  logic                         req_tready,
   input  logic [salru_pkg::ADDR_W-1:0] req_tdata,   // [47:0] address
   input  logic                         req_tuser,   // [0] kind
   input  logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   input  logic [7:0]                   rsp_tdata,   // [0] hit, [2:1] way, [3] replaced_valid,
                                                     // [7:4] zero
   output int                           mismatch_count,
   output int                           outstanding_count,
   output int                           lookup_count,
   output int                           lookup_hit_count,
   output int                           fill_count,
   output int                           eviction_count
);

   // What one transaction on rsp should carry
   typedef struct packed {
      logic                            hit;
      logic [salru_pkg::OUT_WAY_W-1:0] way;
      logic                            replaced;
   } access_outcome_type;

   typedef struct {
      salru_pkg::kind_type          kind;
      logic [salru_pkg::ADDR_W-1:0] addr;
      access_outcome_type           outcome;
   } pending_access_type;

   // Shadow copy of the tag array
   logic [salru_pkg::TAG_W-1:0] shadow_tag   [salru_pkg::SET_COUNT][salru_pkg::NUM_WAYS];
   bit                          shadow_valid [salru_pkg::SET_COUNT][salru_pkg::NUM_WAYS];
   int unsigned                 shadow_age   [salru_pkg::SET_COUNT][salru_pkg::NUM_WAYS];

   pending_access_type pending_accesses[$];

   // Apply one lookup or fill to the shadow array and return its outcome
   function automatic access_outcome_type predict_access(
      input salru_pkg::kind_type          kind,
      input logic [salru_pkg::ADDR_W-1:0] addr);
      logic [salru_pkg::ADDR_W-1:0] a;
      int unsigned                  set_idx;
      logic [salru_pkg::TAG_W-1:0]  tag;
      int                           hit_way;
      int unsigned                  hit_age;
      int                           victim;
      int unsigned                  oldest;
      bit                           found_free;
      access_outcome_type           o;
      a       = addr & salru_pkg::ADDR_MASK;
      set_idx = int'(a[salru_pkg::OFS +: salru_pkg::SETB]) % salru_pkg::SET_COUNT;
      tag     = salru_pkg::HAS_TAG ? salru_pkg::TAG_W'(a >> salru_pkg::LOW) : '0;
      o       = '0;
      if (kind == salru_pkg::KIND_LOOKUP) begin
         hit_way = -1;
         for (int w = 0; w < salru_pkg::NUM_WAYS; w++) begin
            if (shadow_valid[set_idx][w] && shadow_tag[set_idx][w] == tag) begin
               hit_way = w;
               break;
            end
         end
         if (hit_way >= 0) begin
            // younger ways age by one, invalid ones included
            hit_age = shadow_age[set_idx][hit_way];
            for (int w = 0; w < salru_pkg::NUM_WAYS; w++) begin
               if (shadow_age[set_idx][w] < hit_age) shadow_age[set_idx][w]++;
            end
            shadow_age[set_idx][hit_way] = 0;
            o.hit = 1'b1;
            o.way = salru_pkg::OUT_WAY_W'(hit_way);
         end
      end else begin
         // first free way, else the oldest one with the later way winning ties
         victim     = 0;
         oldest     = 0;
         found_free = 1'b0;
         for (int w = 0; w < salru_pkg::NUM_WAYS; w++) begin
            if (!shadow_valid[set_idx][w]) begin
               victim     = w;
               found_free = 1'b1;
               break;
            end
            if (shadow_age[set_idx][w] >= oldest) begin
               oldest = shadow_age[set_idx][w];
               victim = w;
            end
         end
         for (int w = 0; w < salru_pkg::NUM_WAYS; w++) begin
            if (shadow_age[set_idx][w] < salru_pkg::NUM_WAYS - 1) shadow_age[set_idx][w]++;
         end
         shadow_age[set_idx][victim]   = 0;
         shadow_valid[set_idx][victim] = 1'b1;
         shadow_tag[set_idx][victim]   = tag;
         o.way      = salru_pkg::OUT_WAY_W'(victim);
         o.replaced = !found_free;
      end
      return o;
   endfunction

   // Sample both channels at the rising edge; retire responses before new requests
   always @(posedge clock) begin
      pending_access_type pa;
      access_outcome_type got;
      if (reset) begin
         for (int s = 0; s < salru_pkg::SET_COUNT; s++) begin
            for (int w = 0; w < salru_pkg::NUM_WAYS; w++) begin
               shadow_valid[s][w] = 1'b0;
               shadow_age[s][w]   = 0;
               shadow_tag[s][w]   = '0;
            end
         end
         pending_accesses.delete();
         mismatch_count   = 0;
         lookup_count     = 0;
         lookup_hit_count = 0;
         fill_count       = 0;
         eviction_count   = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = {rsp_tdata[0], rsp_tdata[2:1], rsp_tdata[3]};
            if (pending_accesses.size() == 0) begin
               if (mismatch_count < 10)
                  $display("%0t: response with no request waiting: data %h", $realtime,
                           rsp_tdata);
               mismatch_count++;
            end else begin
               pa = pending_accesses.pop_front();
               if (got.hit !== pa.outcome.hit || got.way !== pa.outcome.way ||
                   got.replaced !== pa.outcome.replaced || rsp_tdata[7:4] !== 4'd0) begin
                  if (mismatch_count < 10)
                     $display({"%0t: %s %h: got hit %b way %0d repl %b pad %h, ",
                               "expected hit %b way %0d repl %b pad 0"},
                              $realtime, pa.kind.name(), pa.addr, got.hit, got.way,
                              got.replaced, rsp_tdata[7:4], pa.outcome.hit,
                              pa.outcome.way, pa.outcome.replaced);
                  mismatch_count++;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            pa.kind    = salru_pkg::kind_type'(req_tuser);
            pa.addr    = req_tdata;
            pa.outcome = predict_access(pa.kind, pa.addr);
            pending_accesses.push_back(pa);
            if (pa.kind == salru_pkg::KIND_LOOKUP) begin
               lookup_count++;
               if (pa.outcome.hit) lookup_hit_count++;
            end else begin
               fill_count++;
               if (pa.outcome.replaced) eviction_count++;
            end
         end
      end
      outstanding_count = pending_accesses.size();
   end

endmodule

/* tb/set_assoc_tag_lru_engine_core_tb.sv */
`timescale 1ns / 100ps
// Testbench top for set_assoc_tag_lru_engine_core: drives lookups and fills
// with random gaps and response stalls; checking lives in the checker module.
// Depends on salru_pkg, the engine RTL and set_assoc_tag_lru_engine_core_checker.
module set_assoc_tag_lru_engine_core_tb;

   typedef logic [salru_pkg::TAG_W-1:0]  tag_type;
   typedef logic [salru_pkg::SETB-1:0]   set_type;
   typedef logic [salru_pkg::OFS-1:0]    ofs_type;
   typedef logic [salru_pkg::ADDR_W-1:0] addr_type;

   localparam int RANDOM_ACCESSES = 1450;
   localparam int QUIET_TAIL      = 200;
   localparam int CYCLE_LIMIT     = 200000;
   localparam int DRAIN_CYCLES    = 8;
   localparam int HOT_TAGS        = 8;
   localparam int HOT_SETS        = 4;
   localparam tag_type TAG_MAX    = '1;

   logic              clock      = 1'b0;
   logic              reset      = 1'b1;
   logic              req_tvalid = 1'b0;
   logic              req_tready;
   addr_type          req_tdata  = '0;   // [47:0] address
   logic              req_tuser  = 1'b0; // [0] kind (0 lookup, 1 fill)
   logic              rsp_tvalid;
   logic              rsp_tready = 1'b1;
   logic [7:0]        rsp_tdata;         // [0] hit, [2:1] way, [3] replaced_valid, [7:4] zero

   int mismatch_count, outstanding_count;
   int lookup_count, lookup_hit_count, fill_count, eviction_count;
   int cycle_count;
   int stall_left = 0;
   bit gaps_on = 1'b1;

   tag_type hot_tag [HOT_TAGS];
   set_type hot_set [HOT_SETS];

   always #1 clock = ~clock;

   set_assoc_tag_lru_engine_core u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   set_assoc_tag_lru_engine_core_checker u_checker (
      .clock             (clock),
      .reset             (reset),
      .req_tvalid        (req_tvalid),
      .req_tready        (req_tready),
      .req_tdata         (req_tdata),
      .req_tuser         (req_tuser),
      .rsp_tvalid        (rsp_tvalid),
      .rsp_tready        (rsp_tready),
      .rsp_tdata         (rsp_tdata),
      .mismatch_count    (mismatch_count),
      .outstanding_count (outstanding_count),
      .lookup_count      (lookup_count),
      .lookup_hit_count  (lookup_hit_count),
      .fill_count        (fill_count),
      .eviction_count    (eviction_count)
   );

   // Response-side back-pressure in random bursts
   always @(negedge clock) begin
      if (stall_left > 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else if (gaps_on && $urandom_range(0, 7) == 0) begin
         stall_left = $urandom_range(1, 11) - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Byte address from tag, set and line offset
   function automatic addr_type line_addr(input tag_type tag, input set_type set_idx,
                                          input ofs_type offset);
      return {tag, set_idx, offset};
   endfunction

   // One request transaction; called and returns at a falling edge
   task automatic send_access(input salru_pkg::kind_type kind, input addr_type addr);
      int gap;
      if (gaps_on && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 11);
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= addr;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   // Watchdog
   initial begin : watchdog
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("[FAIL] regression broken");
      $finish;
   end

   initial begin : stimulus
      salru_pkg::kind_type kind;
      tag_type             tag;
      set_type             set_idx;
      addr_type            addr;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: empty set, duplicate fill, aging with free ways, evictions
      send_access(salru_pkg::KIND_LOOKUP, line_addr('0, '0, '0));
      send_access(salru_pkg::KIND_FILL,   line_addr('0, '0, '0));
      send_access(salru_pkg::KIND_LOOKUP, line_addr('0, '0, '1));
      send_access(salru_pkg::KIND_FILL,   '1);
      send_access(salru_pkg::KIND_LOOKUP, line_addr(TAG_MAX, '1, '0));
      send_access(salru_pkg::KIND_FILL,   line_addr('0, '0, ofs_type'(5)));
      send_access(salru_pkg::KIND_LOOKUP, line_addr('0, '0, '0));
      send_access(salru_pkg::KIND_FILL,   line_addr(tag_type'(1), '0, '0));
      send_access(salru_pkg::KIND_LOOKUP, line_addr(tag_type'(1), '0, '0));
      send_access(salru_pkg::KIND_FILL,   line_addr(TAG_MAX, '0, '0));
      send_access(salru_pkg::KIND_LOOKUP, line_addr('0, '0, '0));
      send_access(salru_pkg::KIND_FILL,   line_addr(tag_type'(2), '0, '0));
      send_access(salru_pkg::KIND_FILL,   line_addr(tag_type'(3), '0, '0));
      send_access(salru_pkg::KIND_LOOKUP, line_addr(tag_type'(1), '0, '0));
      send_access(salru_pkg::KIND_LOOKUP,
                  line_addr(tag_type'(1) << (salru_pkg::TAG_W - 1), '0, '0));
      send_access(salru_pkg::KIND_LOOKUP, line_addr(TAG_MAX, '0, '0));
      send_access(salru_pkg::KIND_FILL,
                  line_addr(tag_type'(36'h5_5555_5555), set_type'(42), ofs_type'(21)));
      send_access(salru_pkg::KIND_LOOKUP,
                  line_addr(tag_type'(36'h5_5555_5555), set_type'(42), ofs_type'(21)));
      send_access(salru_pkg::KIND_LOOKUP,
                  line_addr(tag_type'(36'hA_AAAA_AAAA), set_type'(21), ofs_type'(42)));
      send_access(salru_pkg::KIND_FILL,   line_addr(tag_type'(4), '0, '0));
      send_access(salru_pkg::KIND_FILL,   line_addr(tag_type'(5), '0, '0));
      send_access(salru_pkg::KIND_LOOKUP, line_addr(tag_type'(2), '0, '0));
      send_access(salru_pkg::KIND_LOOKUP, line_addr(tag_type'(3), '0, '0));

      // Random: mostly a small working set so sets fill, hit and evict
      foreach (hot_tag[i]) hot_tag[i] = tag_type'({$urandom, $urandom});
      foreach (hot_set[i]) hot_set[i] = set_type'($urandom);
      for (int n = 0; n < RANDOM_ACCESSES; n++) begin
         gaps_on = !(n >= 500 && n < 650) && (n < RANDOM_ACCESSES - QUIET_TAIL);
         if (n % 100 == 99) begin
            hot_tag[$urandom_range(0, HOT_TAGS - 1)] = tag_type'({$urandom, $urandom});
            hot_set[$urandom_range(0, HOT_SETS - 1)] = set_type'($urandom);
         end
         kind = ($urandom_range(0, 99) < 40) ? salru_pkg::KIND_FILL : salru_pkg::KIND_LOOKUP;
         if ($urandom_range(0, 99) < 80) begin
            tag     = hot_tag[$urandom_range(0, HOT_TAGS - 1)];
            set_idx = hot_set[$urandom_range(0, HOT_SETS - 1)];
            addr    = line_addr(tag, set_idx, ofs_type'($urandom));
         end else begin
            addr = addr_type'({$urandom, $urandom});
         end
         send_access(kind, addr);
      end
      req_tvalid <= 1'b0;

      // Drain and settle
      while (outstanding_count != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);

      $display("Covered %0d lookups (%0d hits) and %0d fills (%0d evicted a valid line)",
               lookup_count, lookup_hit_count, fill_count, eviction_count);
      $display("in %0d cycles, %0d mismatching responses", cycle_count, mismatch_count);
      if (mismatch_count == 0 && outstanding_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
